// ===== rtl/core/sorted_alarm_scheduler_core_macros.svh =====
// Assertion macros for the alarm scheduler core.
`ifndef SORTED_ALARM_SCHEDULER_CORE_MACROS_SVH
`define SORTED_ALARM_SCHEDULER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SAS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SAS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/sas_pkg.sv =====
package sas_pkg;

  localparam int SLOTS = 8;
  localparam int MAX_FIRES = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int FIRE_W = $clog2(MAX_FIRES + 1);
  localparam int QDEPTH = 2;

  localparam logic [1:0] OP_ONESHOT  = 2'd0;
  localparam logic [1:0] OP_PERIODIC = 2'd1;
  localparam logic [1:0] OP_CANCEL   = 2'd2;
  localparam logic [1:0] OP_CHECK    = 2'd3;

  localparam logic [15:0] RELOAD_MAX = 16'hFFFF;
  localparam logic [63:0] RELOAD_SPAN = 64'h10000;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  slot;
    logic [63:0] current_time;
    logic [63:0] time_value;
    logic [63:0] reload_period;
  } in_item_t;

  typedef struct packed {
    logic        fired;
    logic [2:0]  fired_slot;
    logic        timer_update;
    logic        timer_running;
    logic [15:0] timer_reload;
    logic        last;
  } out_item_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic        is_check;
    logic        is_cancel;
    logic        is_set;
    logic [SLOT_W-1:0] slot;
    logic [63:0] now;
    logic [63:0] fire_at;
    logic [63:0] period;
  } cmd_t;

endpackage

// ===== rtl/core/sas_front.sv =====
module sas_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sas_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output sas_pkg::cmd_t     cmd,
  input  logic              cmd_take
);

  sas_pkg::cmd_t q [sas_pkg::QDEPTH];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;
  logic       pop;
  sas_pkg::cmd_t enc;
  logic       in_range;

  // Decode the operation; out-of-range slots become no-ops.
  always_comb begin
    in_range = ({29'd0, in_item.slot} < 32'(sas_pkg::SLOTS));
    enc.is_check  = (in_item.op == sas_pkg::OP_CHECK);
    enc.is_cancel = (in_item.op == sas_pkg::OP_CANCEL) && in_range;
    enc.is_set    = ((in_item.op == sas_pkg::OP_ONESHOT) ||
                     (in_item.op == sas_pkg::OP_PERIODIC)) && in_range;
    enc.slot      = in_item.slot[sas_pkg::SLOT_W-1:0];
    enc.now       = in_item.current_time;
    if (in_item.op == sas_pkg::OP_ONESHOT) begin
      enc.fire_at = in_item.current_time + in_item.time_value;
      enc.period  = 64'd0;
    end else begin
      enc.fire_at = in_item.time_value;
      enc.period  = in_item.reload_period;
    end
  end

  assign busy = (count == 2'(sas_pkg::QDEPTH));
  assign push = start && !busy;
  assign pop  = cmd_take && cmd_valid;
  assign cmd_valid = (count != 2'd0);
  assign cmd = q[rd_ptr];

  // Short command queue between the two halves.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        q[wr_ptr] <= enc;
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/sas_back.sv =====
module sas_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  sas_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               result_strobe,
  output sas_pkg::out_item_t result
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UNLINK = 3'd1;
  localparam logic [2:0] ST_LINK   = 3'd2;
  localparam logic [2:0] ST_HEAD   = 3'd3;
  localparam logic [2:0] ST_STATUS = 3'd4;

  localparam int SW = sas_pkg::SLOT_W;

  logic [2:0]    state;
  sas_pkg::cmd_t cur;
  logic [63:0]   fire_time [sas_pkg::SLOTS];
  logic [63:0]   period_store [sas_pkg::SLOTS];
  logic [SW-1:0] queue_rank [sas_pkg::SLOTS];
  logic [sas_pkg::SLOTS-1:0] slot_active;
  logic [SW-1:0] tgt;
  logic [sas_pkg::FIRE_W-1:0] fires;
  logic          upd;
  logic          firing;
  logic          head_found;
  logic [SW-1:0] head;
  logic [SW:0]   link_rank;
  logic [63:0]   diff;
  logic [15:0]   reload;

  // Head lookup: the active slot with rank zero.
  always_comb begin
    head_found = 1'b0;
    head = '0;
    for (int t = 0; t < sas_pkg::SLOTS; t++) begin
      if (slot_active[t] && queue_rank[t] == '0) begin
        head_found = 1'b1;
        head = SW'(t);
      end
    end
  end

  // New rank of the target: count of active slots due no later.
  always_comb begin
    link_rank = '0;
    for (int t = 0; t < sas_pkg::SLOTS; t++) begin
      if (slot_active[t] && fire_time[t] <= fire_time[tgt]) begin
        link_rank = link_rank + 1'b1;
      end
    end
  end

  // Reload value from head distance.
  always_comb begin
    diff = fire_time[head] - cur.now;
    if (!head_found) begin
      reload = 16'd0;
    end else if (diff[63]) begin
      reload = sas_pkg::RELOAD_MAX;
    end else if (diff < sas_pkg::RELOAD_SPAN) begin
      reload = sas_pkg::RELOAD_MAX - diff[15:0];
    end else begin
      reload = 16'd0;
    end
  end

  assign cmd_take = (state == ST_IDLE) && cmd_valid;

  // Sequencer: unlink, relink and fire steps on the slot table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_active   <= '0;
      result_strobe <= 1'b0;
      fires         <= '0;
      upd           <= 1'b0;
      firing        <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur    <= cmd;
            tgt    <= cmd.slot;
            fires  <= '0;
            upd    <= cmd.is_check;
            firing <= 1'b0;
            if (cmd.is_check) begin
              state <= ST_HEAD;
            end else if (cmd.is_set || cmd.is_cancel) begin
              state <= ST_UNLINK;
            end else begin
              state <= ST_STATUS;
            end
          end
        end
        ST_UNLINK: begin
          if (slot_active[tgt]) begin
            slot_active[tgt] <= 1'b0;
            for (int t = 0; t < sas_pkg::SLOTS; t++) begin
              if (slot_active[t] && queue_rank[t] > queue_rank[tgt]) begin
                queue_rank[t] <= queue_rank[t] - 1'b1;
              end
            end
            if (queue_rank[tgt] == '0 && !firing) begin
              upd <= 1'b1;
            end
          end
          if (firing) begin
            if (period_store[tgt] != 64'd0) begin
              fire_time[tgt] <= fire_time[tgt] + period_store[tgt];
              state <= ST_LINK;
            end else begin
              state <= ST_HEAD;
            end
          end else if (cur.is_set) begin
            fire_time[tgt]    <= cur.fire_at;
            period_store[tgt] <= cur.period;
            state <= ST_LINK;
          end else begin
            state <= ST_STATUS;
          end
        end
        ST_LINK: begin
          for (int t = 0; t < sas_pkg::SLOTS; t++) begin
            if (slot_active[t] && {1'b0, queue_rank[t]} >= link_rank) begin
              queue_rank[t] <= queue_rank[t] + 1'b1;
            end
          end
          queue_rank[tgt]  <= link_rank[SW-1:0];
          slot_active[tgt] <= 1'b1;
          if (link_rank == '0 && !firing) begin
            upd <= 1'b1;
          end
          state <= firing ? ST_HEAD : ST_STATUS;
        end
        ST_HEAD: begin
          if (fires != sas_pkg::FIRE_W'(sas_pkg::MAX_FIRES) && head_found &&
              !(cur.now < fire_time[head])) begin
            result_strobe <= 1'b1;
            result <= '{fired: 1'b1, fired_slot: 3'(head), timer_update: 1'b0,
                        timer_running: 1'b0, timer_reload: 16'd0, last: 1'b0};
            fires  <= fires + 1'b1;
            tgt    <= head;
            firing <= 1'b1;
            state  <= ST_UNLINK;
          end else begin
            state <= ST_STATUS;
          end
        end
        ST_STATUS: begin
          result_strobe <= 1'b1;
          result <= '{fired: 1'b0, fired_slot: 3'd0, timer_update: upd,
                      timer_running: head_found, timer_reload: reload, last: 1'b1};
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/sorted_alarm_scheduler_core.sv =====
// Channel   Handshake            Payload
// command   start / busy         cmd  (sas_pkg::in_item_t)
// result    result_strobe only   result (sas_pkg::out_item_t)
//
// A set passes from the queue hand-off through unlink and relink to its status
// transfer, and a cancel takes the same path without the relink. A check runs
// head steps, each fire adding an unlink and, for a periodic fire, a relink,
// with at most MAX_FIRES fires; the two-entry command queue lets start be
// taken while the back end works. Reset is synchronous and clears all slots.
// Results cannot be stalled: each is shown for one cycle.
`include "sorted_alarm_scheduler_core_macros.svh"
module sorted_alarm_scheduler_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  sas_pkg::in_item_t  cmd,
  output logic               result_strobe,
  output sas_pkg::out_item_t result
);

  logic          cmd_valid;
  logic          cmd_take;
  sas_pkg::cmd_t q_cmd;

  sas_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(cmd),
    .cmd_valid(cmd_valid), .cmd(q_cmd), .cmd_take(cmd_take)
  );

  sas_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(q_cmd), .cmd_take(cmd_take),
    .result_strobe(result_strobe), .result(result)
  );

  `SAS_ASSERT_IMPL(a_fire_not_last, clk, rst, result_strobe && result.fired,
                   !result.last, "fire result marked last")
  `SAS_ASSERT_IMPL(a_status_clean, clk, rst, result_strobe && result.last,
                   !result.fired && result.fired_slot == 3'd0, "status result has fire data")
  `SAS_ASSERT_NEXT(a_take_empties, clk, rst, cmd_take, !cmd_take, "back end took two commands")

endmodule
